### rtl/core/sle_pkg.sv
// Shared types for the sequential list engine: op codes, status codes,
// cell commands and the result beat layout. No dependencies.
`default_nettype none

package sle_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 5;
  localparam int unsigned IdxOutW = 4;
  localparam int unsigned LenOutW = 5;

  typedef enum logic [1:0] {
    MODE_FIND   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_INS   = 3'd1,
    CELL_DEL   = 3'd2,
    CELL_MATCH = 3'd3,
    CELL_SHIFT = 3'd4
  } cell_op_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e          op;
    logic [ValueW-1:0] value;
  } cell_cmd_t;

  // result beat, status in the lowest bits
  typedef struct packed {
    logic [LenOutW-1:0] length;
    logic [IdxOutW-1:0] found_index;
    status_e            status;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/sequential_list_engine.sv
// Top level of the sequential list engine: command decode, scan sequencer,
// output register and the chain of sle_cell. Depends on sle_pkg, sle_cell.
//
//  port group   dir  beat contents (lowest bit first)
//  s_axis_*     in   mode[1:0] position[6:2] value[38:7], zero pad to 40
//  m_axis_*     out  status[1:0] found_index[5:2] length[10:6], pad to 16
//
// Insert, delete and the refused or unused operations finish in the beat's
// accept cycle. Find loads a match flag into every cell, then the flags
// step down the chain one cell per cycle past cell 0 until cell 0 shows a
// hit or the scan reaches the length; the input is not ready meanwhile.
// Reset clears the length and the control state; entries are not cleared.
// A result waits in the output register; with it full, a finishing item
// parks its result and the input stalls until the register drains.
`default_nettype none

module sequential_list_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // mode, position, value
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata    // status, found_index, length
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned WideW = ((CntW > sle_pkg::PosW) ? CntW : sle_pkg::PosW) + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     k_q, k_d;
  logic                m_valid_q, m_valid_d;
  sle_pkg::result_t    m_res_q, m_res_d;
  sle_pkg::result_t    park_q, park_d;

  // beat fields
  sle_pkg::mode_e                 in_mode;
  logic [sle_pkg::PosW-1:0]       in_pos;
  logic [sle_pkg::ValueW-1:0]     in_value;
  assign in_mode  = sle_pkg::mode_e'(s_axis_tdata[1:0]);
  assign in_pos   = s_axis_tdata[6:2];
  assign in_value = s_axis_tdata[38:7];

  logic accept, out_free;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // bounds checks at a width that holds both position and length
  logic [WideW-1:0]         pos_w, cnt_w;
  logic [sle_pkg::PosW-1:0] tgt;
  logic                     ins_full, ins_bad, del_bad;
  assign pos_w    = WideW'(in_pos);
  assign cnt_w    = WideW'(count_q);
  assign tgt      = in_pos - sle_pkg::PosW'(1);
  assign ins_full = (cnt_w >= WideW'(CAPACITY));
  assign ins_bad  = (in_pos == '0) || (pos_w > cnt_w + WideW'(1));
  assign del_bad  = (in_pos == '0) || (pos_w > cnt_w);

  // cell chain
  sle_pkg::cell_cmd_t         cmd;
  logic [sle_pkg::ValueW-1:0] entry_w [CAPACITY];
  logic                       flag_w  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [sle_pkg::ValueW-1:0] left_v, right_v;
    logic                       right_f;
    if (i == 0) begin : g_lo
      assign left_v = entry_w[i];
    end else begin : g_mid
      assign left_v = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign right_v = entry_w[i];
      assign right_f = 1'b0;
    end else begin : g_up
      assign right_v = entry_w[i+1];
      assign right_f = flag_w[i+1];
    end

    sle_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .at_tgt_i     (WideW'(i) == WideW'(tgt)),
      .past_tgt_i   (WideW'(i) >  WideW'(tgt)),
      .left_i       (left_v),
      .right_i      (right_v),
      .right_flag_i (right_f),
      .entry_o      (entry_w[i]),
      .flag_o       (flag_w[i])
    );
  end

  // sequencer
  logic             fin;
  sle_pkg::result_t fin_res;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    k_d       = k_q;
    park_d    = park_q;
    m_valid_d = m_valid_q;
    m_res_d   = m_res_q;
    cmd.op    = sle_pkg::CELL_HOLD;
    cmd.value = in_value;
    fin       = 1'b0;
    fin_res.status      = sle_pkg::ST_OK;
    fin_res.found_index = '0;
    fin_res.length      = sle_pkg::LenOutW'(count_q);

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            sle_pkg::MODE_FIND: begin
              cmd.op  = sle_pkg::CELL_MATCH;
              k_d     = '0;
              state_d = S_SCAN;
            end
            sle_pkg::MODE_INSERT: begin
              fin = 1'b1;
              if (ins_full) begin
                fin_res.status = sle_pkg::ST_FULL;
              end else if (ins_bad) begin
                fin_res.status = sle_pkg::ST_BADPOS;
              end else begin
                cmd.op         = sle_pkg::CELL_INS;
                count_d        = count_q + CntW'(1);
                fin_res.length = sle_pkg::LenOutW'(count_d);
              end
            end
            sle_pkg::MODE_DELETE: begin
              fin = 1'b1;
              if (del_bad) begin
                fin_res.status = sle_pkg::ST_BADPOS;
              end else begin
                cmd.op         = sle_pkg::CELL_DEL;
                count_d        = count_q - CntW'(1);
                fin_res.length = sle_pkg::LenOutW'(count_d);
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // end of list is tested first: flags past the length are stale
        if (k_q == count_q) begin
          fin            = 1'b1;
          fin_res.status = sle_pkg::ST_NOTFOUND;
        end else if (flag_w[0]) begin
          fin                 = 1'b1;
          fin_res.found_index = sle_pkg::IdxOutW'(k_q);
        end else begin
          cmd.op = sle_pkg::CELL_SHIFT;
          k_d    = k_q + CntW'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_res_d   = park_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        m_valid_d = 1'b1;
        m_res_d   = fin_res;
        state_d   = S_IDLE;
      end else begin
        park_d  = fin_res;
        state_d = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      k_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      k_q       <= k_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_res_q <= m_res_d;
    park_q  <= park_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b0, m_res_q};

endmodule

`default_nettype wire

### rtl/core/sle_cell.sv
// One list cell: holds one entry and a match flag, trades both with its
// neighbours. Depends on sle_pkg.
`default_nettype none

module sle_cell (
  input  wire logic                        clk_i,
  input  wire sle_pkg::cell_cmd_t          cmd_i,
  input  wire logic                        at_tgt_i,    // this cell is the target slot
  input  wire logic                        past_tgt_i,  // this cell lies above the target
  input  wire logic [sle_pkg::ValueW-1:0]  left_i,      // entry of the lower neighbour
  input  wire logic [sle_pkg::ValueW-1:0]  right_i,     // entry of the upper neighbour
  input  wire logic                        right_flag_i,
  output logic      [sle_pkg::ValueW-1:0]  entry_o,
  output logic                             flag_o
);

  logic [sle_pkg::ValueW-1:0] entry_q, entry_d;
  logic                       flag_q, flag_d;

  always_comb begin
    entry_d = entry_q;
    flag_d  = flag_q;
    unique case (cmd_i.op)
      sle_pkg::CELL_HOLD: begin
      end
      sle_pkg::CELL_INS: begin
        if (at_tgt_i) begin
          entry_d = cmd_i.value;
        end else if (past_tgt_i) begin
          entry_d = left_i;
        end
      end
      sle_pkg::CELL_DEL: begin
        if (at_tgt_i || past_tgt_i) begin
          entry_d = right_i;
        end
      end
      sle_pkg::CELL_MATCH: begin
        flag_d = (entry_q == cmd_i.value);
      end
      sle_pkg::CELL_SHIFT: begin
        flag_d = right_flag_i;
      end
      default: begin
      end
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    flag_q  <= flag_d;
  end

  assign entry_o = entry_q;
  assign flag_o  = flag_q;

endmodule

`default_nettype wire

### rtl/core/sle_checker.sv
// Port-level checks for sequential_list_engine, bound to the top level.
// Depends on sle_pkg for status codes.
`default_nettype none

module sle_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [39:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  logic [1:0] st;
  logic [3:0] idx;
  logic [4:0] len;
  assign st  = m_axis_tdata[1:0];
  assign idx = m_axis_tdata[5:2];
  assign len = m_axis_tdata[10:6];

  logic unused_in;
  assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (CAPACITY < 32) |-> len <= 5'(CAPACITY))
    else $error("length above capacity");

  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && idx != 4'd0 |-> st == sle_pkg::ST_OK)
    else $error("index on a failed result");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == sle_pkg::ST_FULL |-> len == 5'(CAPACITY))
    else $error("full status with list not full");

endmodule

bind sequential_list_engine sle_checker #(.CAPACITY(CAPACITY)) u_sle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
